@@ rtl/jic_pkg.sv @@
// Shared types, constants and sequencer states of the joystick input conditioner.
// Used by the top level and by the shared multiply-accumulate unit.
`default_nettype none

package jic_pkg;

	localparam int MV_W      = 13;
	localparam int AXIS_W    = 16;
	localparam int OP_W      = 17;
	localparam int PROD_W    = 2 * OP_W;
	localparam int ACC_W     = PROD_W + 1;
	localparam int Q_FRAC    = 12;
	localparam int CNT_W     = 16;

	localparam int STARTUP_TICKS_DEF = 100;

	localparam logic [MV_W-1:0] POWER_MIN_MV = 13'd4000;
	localparam logic [MV_W-1:0] RIGHT_MIN_MV = 13'd3000;
	localparam logic [MV_W-1:0] LEFT_MAX_MV  = 13'd2000;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_POLL   = 1'b1;

	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	localparam logic [2:0] REG_X_OFFSET  = 3'd0;
	localparam logic [2:0] REG_Y_OFFSET  = 3'd1;
	localparam logic [2:0] REG_X_GAIN    = 3'd2;
	localparam logic [2:0] REG_Y_GAIN    = 3'd3;
	localparam logic [2:0] REG_TOLERANCE = 3'd4;
	localparam logic [2:0] REG_X_REST    = 3'd5;
	localparam logic [2:0] REG_Y_REST    = 3'd6;
	localparam logic [2:0] REG_CHECK_EN  = 3'd7;

	typedef struct packed {
		logic            opcode;
		logic [MV_W-1:0] power_mv;
		logic [MV_W-1:0] x_mv;
		logic [MV_W-1:0] y_mv;
		logic [MV_W-1:0] button_mv;
	} item_t;

	typedef struct packed {
		logic                     connected;
		logic signed [AXIS_W-1:0] x_value;
		logic signed [AXIS_W-1:0] y_value;
		logic                     right_pressed;
		logic                     left_pressed;
		logic                     in_zero;
		logic                     moved;
	} result_t;

	typedef struct packed {
		logic en;
		logic clr;
	} mac_ctrl_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCALE_X,
		ST_SCALE_Y,
		ST_SCALE_WB,
		ST_TOL,
		ST_MOVE_X,
		ST_MOVE_Y,
		ST_MOVE_CMP,
		ST_ZERO_X,
		ST_ZERO_Y,
		ST_ZERO_CMP,
		ST_FIN
	} state_t;

endpackage

`default_nettype wire

@@ rtl/jic_mac.sv @@
// Shared signed multiply-accumulate unit of the joystick input conditioner.
// Depends on jic_pkg for operand and accumulator widths.
`default_nettype none

module jic_mac (
	input  wire logic                            clk,
	input  wire jic_pkg::mac_ctrl_t              ctrl,
	input  wire logic signed [jic_pkg::OP_W-1:0] a,
	input  wire logic signed [jic_pkg::OP_W-1:0] b,
	output logic signed [jic_pkg::ACC_W-1:0]     acc
);
	import jic_pkg::*;

	logic signed [PROD_W-1:0] prod;
	logic signed [ACC_W-1:0]  acc_q;

	assign prod = a * b;

	// A clear restarts the sum with this product; otherwise the product adds on.
	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			acc_q <= (ctrl.clr ? '0 : acc_q)
				+ {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
		end
	end

	assign acc = acc_q;

endmodule

`default_nettype wire

@@ rtl/joystick_input_conditioner.sv @@
// Joystick input conditioner: each item is worked through in steps on the single shared
// multiplier, which forms up to five products per item (two axis scalings or two movement
// squares, one tolerance square and two rest squares). A new item is taken only once the
// sequencer is idle again; a stalled result holds the sequencer. A finished transaction
// waits in the result register while the next one is taken.
// Reset (arst_n low) clears state, counter and the configuration and block state registers
// to their reset values; the working registers and the result data are not reset.
`default_nettype none

module joystick_input_conditioner #(
	parameter int STARTUP_TICKS = jic_pkg::STARTUP_TICKS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// Input item channel.
	input  wire logic                         item_valid,
	output logic                              item_stall,
	input  wire jic_pkg::item_t               item,
	// Result channel.
	output logic                              result_valid,
	input  wire logic                         result_stall,
	output jic_pkg::result_t                  result,
	// Configuration port.
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [jic_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [jic_pkg::PDATA_W-1:0]  pwdata,
	output logic [jic_pkg::PDATA_W-1:0]       prdata,
	output logic                              pready
);
	import jic_pkg::*;

	// Configuration registers.
	logic [MV_W-1:0]          x_off_q, y_off_q;
	logic signed [AXIS_W-1:0] x_gain_q, y_gain_q;
	logic [AXIS_W-1:0]        tol_q;
	logic signed [AXIS_W-1:0] x_rest_q, y_rest_q;
	logic                     check_en_q;

	// Block state.
	logic [CNT_W-1:0]         count_q;
	logic                     conn_q;
	logic signed [AXIS_W-1:0] x_cur_q, y_cur_q;
	logic signed [AXIS_W-1:0] x_last_q, y_last_q;
	logic [1:0]               btn_q;

	// Per-transaction working registers.
	state_t                   state_q, state_d;
	logic                     op_q;
	logic [MV_W-1:0]          x_mv_q, y_mv_q;
	logic                     moved_q, in_zero_q;
	logic signed [ACC_W-1:0]  tol_sq_q;
	result_t                  result_q;
	logic                     result_valid_q;

	// Multiplier interface.
	mac_ctrl_t                mac_ctrl;
	logic signed [OP_W-1:0]   mac_a, mac_b;
	logic signed [ACC_W-1:0]  mac_acc;

	logic                     cfg_wr;
	logic                     item_acc;
	logic                     res_load;
	logic                     power_ok;
	logic                     at_ticks;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite;
	assign item_acc = item_valid && !item_stall;
	assign item_stall = (state_q != ST_IDLE);
	assign power_ok = (item.power_mv > POWER_MIN_MV);
	assign at_ticks = (count_q == CNT_W'(STARTUP_TICKS));
	// The result register is free when empty or being emptied in this cycle.
	assign res_load = (state_q == ST_FIN) && (!result_valid_q || !result_stall);

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Floor of a Q4.12 product, clamped to the 16-bit axis range.
	function automatic logic signed [AXIS_W-1:0] sat_axis(input logic signed [ACC_W-1:0] p);
		logic signed [ACC_W-Q_FRAC-1:0] q;
		q = p[ACC_W-1:Q_FRAC];
		if (q[ACC_W-Q_FRAC-1:AXIS_W-1] == '0 || q[ACC_W-Q_FRAC-1:AXIS_W-1] == '1) begin
			sat_axis = q[AXIS_W-1:0];
		end else if (q[ACC_W-Q_FRAC-1]) begin
			sat_axis = {1'b1, {(AXIS_W-1){1'b0}}};
		end else begin
			sat_axis = {1'b0, {(AXIS_W-1){1'b1}}};
		end
	endfunction

	// Difference of two axis values, one bit wider so it cannot overflow.
	function automatic logic signed [OP_W-1:0] axis_diff(input logic signed [AXIS_W-1:0] p,
			input logic signed [AXIS_W-1:0] n);
		axis_diff = {p[AXIS_W-1], p} - {n[AXIS_W-1], n};
	endfunction

	// Millivolt sample minus its offset, sign extended to the operand width.
	function automatic logic signed [OP_W-1:0] mv_diff(input logic [MV_W-1:0] mv,
			input logic [MV_W-1:0] off);
		logic signed [MV_W:0] d;
		d = {1'b0, mv} - {1'b0, off};
		mv_diff = {{(OP_W-MV_W-1){d[MV_W]}}, d};
	endfunction

	jic_mac u_mac (
		.clk  (clk),
		.ctrl (mac_ctrl),
		.a    (mac_a),
		.b    (mac_b),
		.acc  (mac_acc)
	);

	// Sequencer: a connected sample scales both axes; with checks enabled the
	// tolerance square comes next, then the poll distance (polls only) and the
	// distance to rest. The movement compare overlaps the first rest square.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					if (item.opcode == OP_SAMPLE && power_ok && at_ticks) begin
						state_d = ST_SCALE_X;
					end else if (check_en_q) begin
						state_d = ST_TOL;
					end else begin
						state_d = ST_FIN;
					end
				end
			end
			ST_SCALE_X:  state_d = ST_SCALE_Y;
			ST_SCALE_Y:  state_d = ST_SCALE_WB;
			ST_SCALE_WB: state_d = check_en_q ? ST_TOL : ST_FIN;
			ST_TOL:      state_d = (op_q == OP_POLL) ? ST_MOVE_X : ST_ZERO_X;
			ST_MOVE_X:   state_d = ST_MOVE_Y;
			ST_MOVE_Y:   state_d = ST_MOVE_CMP;
			ST_MOVE_CMP: state_d = ST_ZERO_Y;
			ST_ZERO_X:   state_d = ST_ZERO_Y;
			ST_ZERO_Y:   state_d = ST_ZERO_CMP;
			ST_ZERO_CMP: state_d = ST_FIN;
			ST_FIN: begin
				if (res_load) begin
					state_d = ST_IDLE;
				end
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	// Multiplier operands for each step.
	always_comb begin
		mac_ctrl = '0;
		mac_a    = '0;
		mac_b    = '0;
		case (state_q)
			ST_SCALE_X: begin
				mac_ctrl = '{en: 1'b1, clr: 1'b1};
				mac_a    = mv_diff(x_mv_q, x_off_q);
				mac_b    = {x_gain_q[AXIS_W-1], x_gain_q};
			end
			ST_SCALE_Y: begin
				mac_ctrl = '{en: 1'b1, clr: 1'b1};
				mac_a    = mv_diff(y_mv_q, y_off_q);
				mac_b    = {y_gain_q[AXIS_W-1], y_gain_q};
			end
			ST_TOL: begin
				mac_ctrl = '{en: 1'b1, clr: 1'b1};
				mac_a    = {1'b0, tol_q};
				mac_b    = {1'b0, tol_q};
			end
			ST_MOVE_X: begin
				mac_ctrl = '{en: 1'b1, clr: 1'b1};
				mac_a    = axis_diff(x_last_q, x_cur_q);
				mac_b    = axis_diff(x_last_q, x_cur_q);
			end
			ST_MOVE_Y: begin
				mac_ctrl = '{en: 1'b1, clr: 1'b0};
				mac_a    = axis_diff(y_last_q, y_cur_q);
				mac_b    = axis_diff(y_last_q, y_cur_q);
			end
			ST_MOVE_CMP, ST_ZERO_X: begin
				mac_ctrl = '{en: 1'b1, clr: 1'b1};
				mac_a    = axis_diff(x_cur_q, x_rest_q);
				mac_b    = axis_diff(x_cur_q, x_rest_q);
			end
			ST_ZERO_Y: begin
				mac_ctrl = '{en: 1'b1, clr: 1'b0};
				mac_a    = axis_diff(y_cur_q, y_rest_q);
				mac_b    = axis_diff(y_cur_q, y_rest_q);
			end
			default: begin
				mac_ctrl = '0;
			end
		endcase
	end

	// Configuration, block state and sequencer registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_off_q        <= '0;
			y_off_q        <= '0;
			x_gain_q       <= 16'sd4096;
			y_gain_q       <= 16'sd4096;
			tol_q          <= '0;
			x_rest_q       <= '0;
			y_rest_q       <= '0;
			check_en_q     <= 1'b0;
			count_q        <= '0;
			conn_q         <= 1'b0;
			x_cur_q        <= '0;
			y_cur_q        <= '0;
			x_last_q       <= '0;
			y_last_q       <= '0;
			btn_q          <= '0;
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_wr) begin
				case (paddr[4:2])
					REG_X_OFFSET:  x_off_q  <= pwdata[MV_W-1:0];
					REG_Y_OFFSET:  y_off_q  <= pwdata[MV_W-1:0];
					REG_X_GAIN:    x_gain_q <= pwdata[AXIS_W-1:0];
					REG_Y_GAIN:    y_gain_q <= pwdata[AXIS_W-1:0];
					REG_TOLERANCE: tol_q    <= pwdata[AXIS_W-1:0];
					REG_X_REST:    x_rest_q <= pwdata[AXIS_W-1:0];
					REG_Y_REST:    y_rest_q <= pwdata[AXIS_W-1:0];
					REG_CHECK_EN: begin
						// Enabling checks starts from the present position.
						check_en_q <= pwdata[0];
						if (pwdata[0]) begin
							x_last_q <= x_cur_q;
							y_last_q <= y_cur_q;
						end
					end
					default: begin
					end
				endcase
			end

			// Supply and startup handling is decided as the sample is taken.
			if (item_acc && item.opcode == OP_SAMPLE) begin
				if (power_ok) begin
					if (at_ticks) begin
						conn_q <= 1'b1;
						btn_q  <= {item.button_mv < LEFT_MAX_MV,
							item.button_mv > RIGHT_MIN_MV};
					end else begin
						count_q <= count_q + 1'b1;
					end
				end else if (count_q != '0) begin
					x_cur_q  <= '0;
					y_cur_q  <= '0;
					x_last_q <= '0;
					y_last_q <= '0;
					btn_q    <= '0;
					count_q  <= '0;
					conn_q   <= 1'b0;
				end
			end

			if (state_q == ST_SCALE_Y) begin
				x_cur_q <= sat_axis(mac_acc);
			end
			if (state_q == ST_SCALE_WB) begin
				y_cur_q <= sat_axis(mac_acc);
			end
			if (state_q == ST_MOVE_CMP) begin
				x_last_q <= x_cur_q;
				y_last_q <= y_cur_q;
			end

			if (res_load) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// Working registers of the running transaction.
	always_ff @(posedge clk) begin
		if (item_acc) begin
			op_q      <= item.opcode;
			x_mv_q    <= item.x_mv;
			y_mv_q    <= item.y_mv;
			moved_q   <= 1'b0;
			in_zero_q <= 1'b1;
		end
		if (state_q == ST_MOVE_X || state_q == ST_ZERO_X) begin
			tol_sq_q <= mac_acc;
		end
		if (state_q == ST_MOVE_CMP) begin
			moved_q <= (mac_acc > tol_sq_q);
		end
		if (state_q == ST_ZERO_CMP) begin
			in_zero_q <= (mac_acc < tol_sq_q);
		end
		if (res_load) begin
			result_q <= '{connected: conn_q, x_value: x_cur_q, y_value: y_cur_q,
				right_pressed: btn_q[0], left_pressed: btn_q[1],
				in_zero: in_zero_q, moved: moved_q};
		end
	end

	// Register read back.
	always_comb begin
		prdata = '0;
		case (paddr[4:2])
			REG_X_OFFSET:  prdata = {{(PDATA_W-MV_W){1'b0}}, x_off_q};
			REG_Y_OFFSET:  prdata = {{(PDATA_W-MV_W){1'b0}}, y_off_q};
			REG_X_GAIN:    prdata = {{(PDATA_W-AXIS_W){x_gain_q[AXIS_W-1]}}, x_gain_q};
			REG_Y_GAIN:    prdata = {{(PDATA_W-AXIS_W){y_gain_q[AXIS_W-1]}}, y_gain_q};
			REG_TOLERANCE: prdata = {{(PDATA_W-AXIS_W){1'b0}}, tol_q};
			REG_X_REST:    prdata = {{(PDATA_W-AXIS_W){x_rest_q[AXIS_W-1]}}, x_rest_q};
			REG_Y_REST:    prdata = {{(PDATA_W-AXIS_W){y_rest_q[AXIS_W-1]}}, y_rest_q};
			REG_CHECK_EN:  prdata = {{(PDATA_W-1){1'b0}}, check_en_q};
			default:       prdata = '0;
		endcase
	end

	// The block is connected only with the startup counter at its final value.
	a_conn_count: assert property (@(posedge clk) disable iff (!arst_n)
		conn_q |-> at_ticks)
		else $error("connected without a completed startup count");

	// Axis values and buttons stay cleared while not connected.
	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!conn_q |-> (x_cur_q == '0 && y_cur_q == '0 && btn_q == '0))
		else $error("axis or button state set while not connected");

	// A new result only appears from the finishing step.
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(state_q == ST_FIN))
		else $error("result register loaded outside the finishing step");

endmodule

`default_nettype wire
